[rtl/core/bmf_pkg.sv]
// Shared types, sizes and helper functions of the box mean filter.
// Used by every module of the block but bmf_ram; depends on nothing else.
package bmf_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 4096;
   localparam int MAX_RADIUS = 3;

   localparam int STORE_ROWS = 2 * MAX_RADIUS;
   localparam int ADDR_W     = $clog2(MAX_WIDTH);
   localparam int BANK_W     = $clog2(STORE_ROWS);
   localparam int PIX_W      = 8;
   localparam int RAD_W      = 2;
   localparam int WID_W      = 11;
   localparam int HGT_W      = 13;
   localparam int CSR_W      = 13;
   localparam int CSR_AW     = 2;
   localparam int COLP_W     = $clog2(MAX_WIDTH + MAX_RADIUS + 1);
   localparam int ROWP_W     = $clog2(MAX_HEIGHT + MAX_RADIUS + 1);
   localparam int OROW_W     = 12;
   localparam int OCOL_W     = 10;
   localparam int VSUM_W     = 11;
   localparam int HSUM_W     = 14;
   localparam int RECIP_W    = 23;
   localparam int RECIP_SH   = 26;
   localparam int PROD_W     = HSUM_W + RECIP_W;
   localparam int QDEPTH     = 8;
   localparam int QPTR_W     = $clog2(QDEPTH);
   localparam int QCNT_W     = $clog2(QDEPTH + 1);

   localparam logic [CSR_AW-1:0] CSR_RADIUS = 2'd0;
   localparam logic [CSR_AW-1:0] CSR_WIDTH  = 2'd1;
   localparam logic [CSR_AW-1:0] CSR_HEIGHT = 2'd2;

   // Kinds of input beat, carried on req_tuser.
   localparam logic CMD_PIXEL = 1'b0;
   localparam logic CMD_FLUSH = 1'b1;

   // One slot of the virtual (rows + R) x (columns + R) scan.
   typedef struct packed {
      logic                valid;
      logic                res;
      logic                colok;
      logic                first;
      logic [PIX_W-1:0]    pix;
      logic [ADDR_W-1:0]   addr;
      logic [BANK_W-1:0]   bank;
      logic [STORE_ROWS-1:0] rowok;
      logic [OROW_W-1:0]   row;
      logic [OCOL_W-1:0]   col;
      logic                last;
   } slot_type;

   typedef struct packed {
      logic                last;
      logic [OCOL_W-1:0]   col;
      logic [OROW_W-1:0]   row;
      logic [PIX_W-1:0]    mean;
   } result_type;

   // Reciprocal of the window area, scaled by 2^RECIP_SH, rounded up.
   function automatic logic [RECIP_W-1:0] recip(input logic [RAD_W-1:0] r);
      logic [RECIP_W-1:0] m;
      case (r)
         2'd2:    m = 23'd2684355;
         2'd3:    m = 23'd1369569;
         default: m = 23'd7456541;
      endcase
      return m;
   endfunction

   // Bank holding the row d rows above the row in bank b.
   function automatic logic [BANK_W-1:0] bank_back(input logic [BANK_W-1:0] b,
                                                   input int unsigned d);
      logic [BANK_W:0] t;
      t = {1'b0, b} + (BANK_W+1)'(STORE_ROWS) - (BANK_W+1)'(d);
      if (t >= (BANK_W+1)'(STORE_ROWS)) t = t - (BANK_W+1)'(STORE_ROWS);
      return t[BANK_W-1:0];
   endfunction

endpackage

[rtl/core/box_mean_filter.sv]
// Box mean filter top level: sequencer, filter pipeline and result queue.
// Uses bmf_pkg, bmf_ctrl, bmf_datapath and bmf_outq.
//
// Pixels come in raster order, one beat per clock; each result beat carries the truncated
// mean of the 3x3, 5x5 or 7x7 window around a pixel, zero outside the image, divided by
// the full window area. The line store is six 1024 x 8 RAM banks read in parallel at the
// current column, so a pixel beat is taken every cycle, except that after the last pixel
// of a row the input stalls while its R trailing results (R = radius) are worked out, and
// it also stalls while eight results are in the pipeline or waiting in the output queue.
// After the frame's last pixel, send R x width flush beats (tuser = 1), or height x width
// if the frame has fewer than R rows; each returns one result of the last R (or all) rows.
// The first R columns of every drain row run without input, so the input stalls before
// each drain row; a frame with fewer than R rows also runs its result-free drain rows
// without input. A result leaves through an eight-beat output queue. A pixel sent during
// the drain starts a new frame. Any write to a configuration register restarts the frame.
module box_mean_filter
   import bmf_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [CSR_AW-1:0] csr_addr,
   input  logic [CSR_W-1:0]  csr_wdata,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [PIX_W-1:0]  req_tdata,   // pixel
   input  logic              req_tuser,   // cmd
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [31:0]       rsp_tdata,   // mean, out_row, out_column, zero fill
   output logic              rsp_tlast
);
   slot_type         slot;
   logic [RAD_W-1:0] r_eff;
   logic             push;
   result_type       push_data;
   result_type       out_data;

   bmf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .pop        (rsp_tvalid && rsp_tready),
      .slot       (slot),
      .r_eff      (r_eff)
   );

   bmf_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .slot      (slot),
      .r_eff     (r_eff),
      .push      (push),
      .push_data (push_data)
   );

   bmf_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_data)
   );

   assign rsp_tdata = {2'b00, out_data.col, out_data.row, out_data.mean};
   assign rsp_tlast = out_data.last;
endmodule

[rtl/core/bmf_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
// Read-first: a read of the address being written returns the old data.
module bmf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

[rtl/core/bmf_ctrl.sv]
// Scan sequencer and configuration registers of the box mean filter.
// Walks the extended scan, gates the input channel and issues slots; uses bmf_pkg.
module bmf_ctrl
   import bmf_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [CSR_AW-1:0] csr_addr,
   input  logic [CSR_W-1:0]  csr_wdata,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic              req_tuser,
   input  logic [PIX_W-1:0]  req_tdata,
   input  logic              pop,
   output slot_type          slot,
   output logic [RAD_W-1:0]  r_eff
);
   logic [RAD_W-1:0]  radius_ff, radius_in;
   logic [WID_W-1:0]  width_ff, width_in;
   logic [HGT_W-1:0]  height_ff, height_in;
   logic [ROWP_W-1:0] row_ff, row_in;
   logic [COLP_W-1:0] col_ff, col_in;
   logic [BANK_W-1:0] bank_ff, bank_in;
   logic [QCNT_W-1:0] used_ff, used_in;

   logic [WID_W-1:0]  w_eff;
   logic [HGT_W-1:0]  h_eff;
   logic [COLP_W-1:0] w_ext;
   logic [ROWP_W-1:0] h_ext;
   logic              in_drain, is_real, res_slot, needs_input, space;
   logic              accept, restart_pix, auto_go, issue, cfg_hit;
   logic [ROWP_W-1:0] sel_row;
   logic [COLP_W-1:0] sel_col;
   logic [BANK_W-1:0] sel_bank;
   logic              sel_res;
   logic [COLP_W-1:0] nxt_col;
   logic [ROWP_W-1:0] nxt_row;

   assign r_eff = (radius_ff == '0) ? RAD_W'(1) : radius_ff;
   assign w_eff = (width_ff == '0) ? WID_W'(1) :
                  (width_ff > WID_W'(MAX_WIDTH)) ? WID_W'(MAX_WIDTH) : width_ff;
   assign h_eff = (height_ff == '0) ? HGT_W'(1) :
                  (height_ff > HGT_W'(MAX_HEIGHT)) ? HGT_W'(MAX_HEIGHT) : height_ff;
   assign w_ext = COLP_W'(w_eff) + COLP_W'(r_eff);
   assign h_ext = ROWP_W'(h_eff) + ROWP_W'(r_eff);

   // Rows past the frame are the drain region; columns past the row end are
   // trailing slots that run on their own outside the drain region.
   assign in_drain    = row_ff >= ROWP_W'(h_eff);
   assign is_real     = !in_drain && (col_ff < COLP_W'(w_eff));
   assign res_slot    = (row_ff >= ROWP_W'(r_eff)) && (col_ff >= COLP_W'(r_eff));
   assign needs_input = is_real || (in_drain && res_slot);
   assign space       = used_ff < QCNT_W'(QDEPTH);

   assign req_tready  = needs_input && space;
   assign accept      = req_tvalid && req_tready;
   assign restart_pix = accept && (req_tuser == CMD_PIXEL) && in_drain;
   assign auto_go     = !needs_input && space;
   assign issue       = auto_go || (accept && !((req_tuser == CMD_FLUSH) && is_real));
   assign cfg_hit     = csr_we && (csr_addr == CSR_RADIUS || csr_addr == CSR_WIDTH ||
                                   csr_addr == CSR_HEIGHT);

   always_comb begin
      if (restart_pix) begin
         sel_row  = '0;
         sel_col  = '0;
         sel_bank = '0;
      end else begin
         sel_row  = row_ff;
         sel_col  = col_ff;
         sel_bank = bank_ff;
      end
   end

   assign sel_res = (sel_row >= ROWP_W'(r_eff)) && (sel_col >= COLP_W'(r_eff));

   always_comb begin
      slot.valid = issue;
      slot.res   = sel_res;
      slot.colok = sel_col < COLP_W'(w_eff);
      slot.first = sel_col == '0;
      slot.pix   = (accept && (req_tuser == CMD_PIXEL)) ? req_tdata : '0;
      slot.addr  = sel_col[ADDR_W-1:0];
      slot.bank  = sel_bank;
      for (int d = 1; d <= STORE_ROWS; d++) begin
         slot.rowok[d-1] = (sel_row >= ROWP_W'(d)) && (d <= 2 * int'(r_eff));
      end
      slot.row  = OROW_W'(sel_row - ROWP_W'(r_eff));
      slot.col  = OCOL_W'(sel_col - COLP_W'(r_eff));
      slot.last = (sel_row == h_ext - ROWP_W'(1)) && (sel_col == w_ext - COLP_W'(1));
   end

   assign nxt_col = sel_col + COLP_W'(1);
   assign nxt_row = sel_row + ROWP_W'(1);

   always_comb begin
      row_in  = row_ff;
      col_in  = col_ff;
      bank_in = bank_ff;
      if (cfg_hit) begin
         row_in  = '0;
         col_in  = '0;
         bank_in = '0;
      end else if (issue) begin
         if (nxt_col == w_ext) begin
            col_in = '0;
            if (nxt_row == h_ext) begin
               row_in  = '0;
               bank_in = '0;
            end else begin
               row_in  = nxt_row;
               bank_in = (sel_bank == BANK_W'(STORE_ROWS - 1)) ? '0 :
                         sel_bank + BANK_W'(1);
            end
         end else begin
            row_in  = sel_row;
            col_in  = nxt_col;
            bank_in = sel_bank;
         end
      end
   end

   // Credits cover queue entries plus results still in the pipeline.
   always_comb begin
      used_in = used_ff;
      if (issue && sel_res) used_in = used_in + QCNT_W'(1);
      if (pop) used_in = used_in - QCNT_W'(1);
   end

   always_comb begin
      radius_in = radius_ff;
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_RADIUS: radius_in = csr_wdata[RAD_W-1:0];
            CSR_WIDTH:  width_in  = csr_wdata[WID_W-1:0];
            CSR_HEIGHT: height_in = csr_wdata[HGT_W-1:0];
            default:    radius_in = radius_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RAD_W'(1);
         width_ff  <= WID_W'(640);
         height_ff <= HGT_W'(480);
         row_ff    <= '0;
         col_ff    <= '0;
         bank_ff   <= '0;
         used_ff   <= '0;
      end else begin
         radius_ff <= radius_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         row_ff    <= row_in;
         col_ff    <= col_in;
         bank_ff   <= bank_in;
         used_ff   <= used_in;
      end
   end

   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= QCNT_W'(QDEPTH)) else $error("credit count overflow");
   a_issue_space: assert property (@(posedge clock) disable iff (reset)
      (issue && sel_res) |-> space) else $error("result issued without credit");
   a_row_range: assert property (@(posedge clock) disable iff (reset)
      row_ff < h_ext) else $error("scan row out of range");
   a_col_range: assert property (@(posedge clock) disable iff (reset)
      col_ff < w_ext) else $error("scan column out of range");
endmodule

[rtl/core/bmf_datapath.sv]
// Line store banks, column and window sums, and division by the window area.
// Uses bmf_pkg and bmf_ram; pipeline stages p1, p2, p3 and p4 lie from slot issue to result.
module bmf_datapath
   import bmf_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  slot_type         slot,
   input  logic [RAD_W-1:0] r_eff,
   output logic             push,
   output result_type       push_data
);
   logic [PIX_W-1:0]  dout [STORE_ROWS];
   slot_type          p1_ff;
   logic [VSUM_W-1:0] vsum;

   logic              p2_valid_ff, p2_res_ff, p2_first_ff;
   logic [VSUM_W-1:0] p2_v_ff;
   logic [OROW_W-1:0] p2_row_ff;
   logic [OCOL_W-1:0] p2_col_ff;
   logic              p2_last_ff;
   logic [VSUM_W-1:0] hist_ff [STORE_ROWS];
   logic [VSUM_W-1:0] hist_in [STORE_ROWS];
   logic [HSUM_W-1:0] hsum;

   logic              p3_valid_ff;
   logic [HSUM_W-1:0] p3_sum_ff;
   logic [OROW_W-1:0] p3_row_ff;
   logic [OCOL_W-1:0] p3_col_ff;
   logic              p3_last_ff;

   logic              p4_valid_ff;
   logic [PROD_W-1:0] p4_prod_ff;
   logic [OROW_W-1:0] p4_row_ff;
   logic [OCOL_W-1:0] p4_col_ff;
   logic              p4_last_ff;

   // One bank per stored row; all banks are read at the slot's column.
   for (genvar i = 0; i < STORE_ROWS; i++) begin : g_bank
      bmf_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_ram (
         .clock (clock),
         .we    (slot.valid && slot.colok && (slot.bank == BANK_W'(i))),
         .waddr (slot.addr),
         .wdata (slot.pix),
         .raddr (slot.addr),
         .rdata (dout[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_ff <= '0;
      end else begin
         p1_ff <= slot;
      end
   end

   always_comb begin
      logic [BANK_W-1:0] b;
      vsum = VSUM_W'(p1_ff.pix);
      for (int d = 1; d <= STORE_ROWS; d++) begin
         b = bank_back(p1_ff.bank, d);
         if (p1_ff.rowok[d-1]) vsum = vsum + VSUM_W'(dout[b]);
      end
      if (!p1_ff.colok) vsum = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_valid_ff <= 1'b0;
      end else begin
         p2_valid_ff <= p1_ff.valid;
      end
      p2_res_ff   <= p1_ff.res;
      p2_first_ff <= p1_ff.first;
      p2_v_ff     <= vsum;
      p2_row_ff   <= p1_ff.row;
      p2_col_ff   <= p1_ff.col;
      p2_last_ff  <= p1_ff.last;
   end

   // Column sums of the current row; a row's first slot drops the history.
   always_comb begin
      hsum = HSUM_W'(p2_v_ff);
      for (int k = 0; k < STORE_ROWS; k++) begin
         if (!p2_first_ff && (k < 2 * int'(r_eff))) hsum = hsum + HSUM_W'(hist_ff[k]);
      end
      hist_in[0] = p2_v_ff;
      for (int k = 1; k < STORE_ROWS; k++) begin
         hist_in[k] = p2_first_ff ? '0 : hist_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (p2_valid_ff) begin
         for (int k = 0; k < STORE_ROWS; k++) hist_ff[k] <= hist_in[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p3_valid_ff <= 1'b0;
         p4_valid_ff <= 1'b0;
      end else begin
         p3_valid_ff <= p2_valid_ff && p2_res_ff;
         p4_valid_ff <= p3_valid_ff;
      end
      p3_sum_ff  <= hsum;
      p3_row_ff  <= p2_row_ff;
      p3_col_ff  <= p2_col_ff;
      p3_last_ff <= p2_last_ff;
      p4_prod_ff <= PROD_W'(p3_sum_ff) * PROD_W'(recip(r_eff));
      p4_row_ff  <= p3_row_ff;
      p4_col_ff  <= p3_col_ff;
      p4_last_ff <= p3_last_ff;
   end

   assign push           = p4_valid_ff;
   assign push_data.mean = p4_prod_ff[RECIP_SH +: PIX_W];
   assign push_data.row  = p4_row_ff;
   assign push_data.col  = p4_col_ff;
   assign push_data.last = p4_last_ff;
endmodule

[rtl/core/bmf_outq.sv]
// Result queue between the filter pipeline and the result channel.
// Uses bmf_pkg; space is reserved ahead by the sequencer's credit count.
module bmf_outq
   import bmf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  result_type push_data,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_data
);
   result_type        mem_ff [QDEPTH];
   logic [QPTR_W-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;
   logic              pop;

   assign out_valid = cnt_ff != '0;
   assign out_data  = mem_ff[rp_ff];
   assign pop       = out_valid && out_ready;

   always_comb begin
      wp_in  = push ? wp_ff + QPTR_W'(1) : wp_ff;
      rp_in  = pop ? rp_ff + QPTR_W'(1) : rp_ff;
      cnt_in = cnt_ff;
      if (push) cnt_in = cnt_in + QCNT_W'(1);
      if (pop) cnt_in = cnt_in - QCNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wp_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (cnt_ff < QCNT_W'(QDEPTH)) || pop) else $error("result queue overflow");
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= QCNT_W'(QDEPTH)) else $error("result queue count out of range");
   a_cnt_hold: assert property (@(posedge clock) disable iff (reset)
      (push && pop) |=> cnt_ff == $past(cnt_ff)) else $error("queue count moved");
endmodule

[tb/box_mean_filter_test.sv]
// Self-checking testbench for box_mean_filter: frames of pixel and flush beats go in,
// and each mean result is compared with an in-bench window-sum model.
// Depends on bmf_pkg and the box_mean_filter RTL only.
`timescale 1ns / 100ps

module box_mean_filter_test
   import bmf_pkg::*;
();

   localparam int CYCLE_LIMIT = 50000;
   localparam int SETTLE      = 40;

   typedef struct {
      bit             cmd;
      logic [7:0]     pix;
   } pixel_beat_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_we = 1'b0;
   logic [CSR_AW-1:0] csr_addr = '0;
   logic [CSR_W-1:0]  csr_wdata = '0;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [PIX_W-1:0]  req_tdata = '0;   // pixel
   logic              req_tuser = 1'b0; // cmd
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [31:0]       rsp_tdata;        // mean, out_row, out_column, zero fill
   logic              rsp_tlast;

   pixel_beat_type beat_q[$];
   result_type  mean_q[$];
   int          errors = 0;
   int          cycles = 0;
   int          pushed = 0;
   bit          quiet = 1'b0;

   // Model state of the filter.
   logic [7:0]  row_store[STORE_ROWS][MAX_WIDTH];
   int          vsum[7];
   int          row_pos, col_pos, pend_cnt;
   int          radius_reg = 1, width_reg = 640, height_reg = 480;

   box_mean_filter dut (.*);

   always #1 clock = ~clock;

   function automatic int eff_radius();
      return radius_reg == 0 ? 1 : radius_reg;
   endfunction
   function automatic int eff_width();
      return width_reg == 0 ? 1 : (width_reg > MAX_WIDTH ? MAX_WIDTH : width_reg);
   endfunction
   function automatic int eff_height();
      return height_reg == 0 ? 1 : (height_reg > MAX_HEIGHT ? MAX_HEIGHT : height_reg);
   endfunction

   function automatic void restart_frame();
      foreach (vsum[i]) vsum[i] = 0;
      row_pos  = 0;
      col_pos  = 0;
      pend_cnt = 0;
   endfunction

   function automatic void push_mean(int sum, int area, int row, int col, bit last);
      result_type res;
      res.mean = 8'(sum / area);
      res.row  = 12'(row);
      res.col  = 10'(col);
      res.last = last;
      mean_q.push_back(res);
   endfunction

   function automatic void predict_means(pixel_beat_type b);
      int r, w, h, area, rows_left, total, k, r0, c0, sum;
      int rlo, rhi, clo, chi, row, col, csum, first, lastc, lo, hi, n;
      bit at_end;
      r = eff_radius();
      w = eff_width();
      h = eff_height();
      area = (2 * r + 1) * (2 * r + 1);
      rows_left = r < h ? r : h;
      if (b.cmd == CMD_FLUSH) begin
         total = rows_left * w;
         if (pend_cnt == 0 || pend_cnt > total) begin
            pend_cnt = 0;
            return;
         end
         k   = total - pend_cnt;
         r0  = (h - rows_left) + k / w;
         c0  = k % w;
         rlo = r0 >= r ? r0 - r : 0;
         rhi = r0 + r < h ? r0 + r : h - 1;
         clo = c0 >= r ? c0 - r : 0;
         chi = c0 + r < w ? c0 + r : w - 1;
         sum = 0;
         for (int rr = rlo; rr <= rhi; rr++)
            for (int cc = clo; cc <= chi; cc++) sum += row_store[rr % STORE_ROWS][cc];
         pend_cnt--;
         push_mean(sum, area, r0, c0, pend_cnt == 0);
         return;
      end
      // A pixel during the drain, or after a frame, starts a new frame.
      if (pend_cnt != 0 || row_pos >= h || col_pos >= w) restart_frame();
      row  = row_pos;
      col  = col_pos;
      csum = b.pix;
      if (col == 0) foreach (vsum[i]) vsum[i] = 0;
      for (int d = 1; d <= 2 * r; d++)
         if (row >= d) csum += row_store[(row - d) % STORE_ROWS][col];
      vsum[col % 7] = csum;
      row_store[row % STORE_ROWS][col] = b.pix;
      if (row >= r) begin
         at_end = (col == w - 1);
         if (col >= r || at_end) begin
            first = col >= r ? col - r : 0;
            lastc = at_end ? w - 1 : first;
            n = 0;
            for (int c = first; c <= lastc && n < 4; c++) begin
               lo  = c >= r ? c - r : 0;
               hi  = c + r < col ? c + r : col;
               sum = 0;
               for (int i = lo; i <= hi; i++) sum += vsum[i % 7];
               push_mean(sum, area, row - r, c, 1'b0);
               n++;
            end
         end
      end
      if (col + 1 < w) begin
         col_pos = col + 1;
      end else begin
         col_pos = 0;
         if (row + 1 < h) begin
            row_pos = row + 1;
         end else begin
            row_pos  = 0;
            pend_cnt = rows_left * w;
         end
      end
   endfunction

   function automatic bit take_gap();
      return !quiet && $urandom_range(99) < 27;
   endfunction

   // Sender: one beat from the queue at a time, with random gaps.
   always @(posedge clock) begin : sender
      pixel_beat_type cur_beat;
      if (req_tvalid && req_tready) predict_means(cur_beat);
      if ((req_tvalid && req_tready) || !req_tvalid) begin
         if (!reset && beat_q.size() > 0 && !take_gap()) begin
            cur_beat = beat_q.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= cur_beat.pix;
            req_tuser  <= cur_beat.cmd;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch on %s: got %0d, expected %0d (cycle %0d)", what, got, want, cycles);
      errors++;
   endtask

   // Receiver: random stalls, each result beat checked against the oldest expectation.
   always @(posedge clock) begin : receiver
      result_type want;
      if (rsp_tvalid && rsp_tready && !reset) begin
         if (mean_q.size() == 0) begin
            report_mismatch("unexpected result, mean", rsp_tdata[7:0], -1);
         end else begin
            want = mean_q.pop_front();
            if (rsp_tdata[7:0] !== want.mean) report_mismatch("mean", rsp_tdata[7:0], want.mean);
            if (rsp_tdata[19:8] !== want.row) report_mismatch("row", rsp_tdata[19:8], want.row);
            if (rsp_tdata[29:20] !== want.col)
               report_mismatch("column", rsp_tdata[29:20], want.col);
            if (rsp_tdata[31:30] !== 2'b00) report_mismatch("fill", rsp_tdata[31:30], 0);
            if (rsp_tlast !== want.last) report_mismatch("last", rsp_tlast, want.last);
         end
      end
      rsp_tready <= !take_gap();
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic wait_drained();
      while (beat_q.size() != 0 || req_tvalid || mean_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_AW-1:0] idx, int value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= CSR_W'(value);
      case (idx)
         CSR_RADIUS: radius_reg = value & 3;
         CSR_WIDTH:  width_reg  = value & 16'h7FF;
         CSR_HEIGHT: height_reg = value & 16'h1FFF;
         default: ;
      endcase
      restart_frame();
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_geometry(int r, int w, int h);
      wait_drained();
      write_reg(CSR_RADIUS, r);
      write_reg(CSR_WIDTH, w);
      write_reg(CSR_HEIGHT, h);
   endtask

   // Random pixels that make up only the start of a frame.
   task automatic queue_pixels(int count);
      pixel_beat_type b;
      for (int i = 0; i < count; i++) begin
         b.cmd = CMD_PIXEL;
         b.pix = 8'($urandom_range(255));
         beat_q.push_back(b);
      end
      pushed += count;
   endtask

   task automatic queue_flushes(int count);
      pixel_beat_type b;
      for (int i = 0; i < count; i++) begin
         b.cmd = CMD_FLUSH;
         b.pix = 8'($urandom_range(255));
         beat_q.push_back(b);
      end
      pushed += count;
   endtask

   // fill: 0 random, 1 all white, 2 all black, 3 checkerboard of extremes.
   task automatic queue_frame(int fill, int flushes);
      pixel_beat_type b;
      int npix;
      npix = eff_width() * eff_height();
      for (int i = 0; i < npix; i++) begin
         b.cmd = CMD_PIXEL;
         case (fill)
            1: b.pix = 8'hFF;
            2: b.pix = 8'h00;
            3: b.pix = ((i / eff_width() + i % eff_width()) % 2) ? 8'hFF : 8'h00;
            default: b.pix = 8'($urandom_range(255));
         endcase
         beat_q.push_back(b);
      end
      pushed += npix;
      queue_flushes(flushes);
   endtask

   function automatic int drain_beats();
      int rl;
      rl = eff_radius() < eff_height() ? eff_radius() : eff_height();
      return rl * eff_width();
   endfunction

   initial begin
      int r;
      restart_frame();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed frames: extremes of pixel values, all radii and edge geometries.
      set_geometry(1, 8, 5);
      queue_frame(3, drain_beats() + 1);
      set_geometry(3, 8, 4);
      queue_frame(1, drain_beats() + 2);
      set_geometry(2, 9, 4);
      queue_frame(2, drain_beats());
      // Radius zero acts as one; zero width and height act as one.
      set_geometry(0, 0, 0);
      queue_frame(1, drain_beats() + 1);
      // Frame shorter than the window.
      set_geometry(3, 9, 2);
      queue_frame(0, drain_beats());
      // Oversized width saturates to the maximum; only the start of a row is sent.
      set_geometry(3, 2047, 8);
      queue_pixels(16);
      // Oversized height saturates to the maximum; only the first rows are sent.
      set_geometry(2, 8, 8191);
      queue_pixels(24);
      // A pixel in the middle of the drain aborts it and starts a new frame.
      set_geometry(2, 8, 5);
      queue_frame(0, 5);
      queue_frame(0, drain_beats());
      wait_drained();
      // Register write in the middle of a frame restarts it.
      queue_pixels(eff_width() * eff_height() - 20);
      wait_drained();
      write_reg(CSR_WIDTH, 1024);
      write_reg(CSR_HEIGHT, 4096);

      // Random frames; the first one runs with no idling on either side.
      quiet = 1'b1;
      while (pushed < 420) begin
         r = $urandom_range(3, 1);
         set_geometry(r, $urandom_range(10, 8), $urandom_range(9, 8));
         queue_frame(0, 0);
         case ($urandom_range(3))
            0: queue_frame(0, 0);
            1: queue_flushes($urandom_range(drain_beats() - 1, 1));
            default: queue_flushes(drain_beats() + $urandom_range(2));
         endcase
         wait_drained();
         quiet = 1'b0;
      end

      wait_drained();
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
